// ----- hdl/board_bus_address_decoder_top_defines.svh -----
// Assertion macros used by the board bus address decoder top level.
`ifndef BOARD_BUS_ADDRESS_DECODER_TOP_DEFINES_SVH
`define BOARD_BUS_ADDRESS_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BBAD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BBAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bbad_pkg.sv -----
// Types, codes and address constants of the board bus address decoder.
package bbad_pkg;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_VBLANK = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    REGION_NONE    = 4'd0,
    REGION_ROM     = 4'd1,
    REGION_WRAM    = 4'd2,
    REGION_PALETTE = 4'd3,
    REGION_CGRAM   = 4'd4,
    REGION_TEXT    = 4'd5,
    REGION_TILEATR = 4'd6,
    REGION_SPRITE  = 4'd7,
    REGION_VICSDAT = 4'd8,
    REGION_VICSCTL = 4'd9,
    REGION_DSPRAM  = 4'd10,
    REGION_COMMS   = 4'd11,
    REGION_POINT   = 4'd12,
    REGION_CZRAM   = 4'd13,
    REGION_MIXER   = 4'd14,
    REGION_EEPROM  = 4'd15
  } region_t;

  localparam int NUM_REGIONS = 15;

  localparam logic [23:0] REGION_LO [NUM_REGIONS] = '{
    24'h000000, 24'hE00000, 24'h828000, 24'h880000, 24'h89E000,
    24'h8A0000, 24'h980000, 24'h900000, 24'h940000, 24'hC00000,
    24'hA04000, 24'hF80000, 24'h810000, 24'h824000, 24'h460000
  };

  localparam logic [23:0] REGION_HI [NUM_REGIONS] = '{
    24'h400000, 24'hE40000, 24'h840000, 24'h89E000, 24'h8A0000,
    24'h8A0010, 24'h9B0000, 24'h910000, 24'h940080, 24'hC20000,
    24'hA0C000, 24'hFA0000, 24'h810400, 24'h824400, 24'h464000
  };

  localparam logic [1:0] CFG_KEYCUS_SEED = 2'd0;
  localparam logic [1:0] CFG_DIP_SWITCH  = 2'd1;
  localparam logic [1:0] CFG_PORT_BITS   = 2'd2;

  localparam logic [23:0] SC_BASE      = 24'h700000;
  localparam logic [23:0] KEY_BASE     = 24'h400000;
  localparam logic [23:0] DIP_BASE     = 24'h440000;
  localparam logic [23:0] PORT_BASE    = 24'h450000;
  localparam logic [23:0] CS_BASE      = 24'h800000;

  localparam logic [4:0] SC_VBLANK_ACK  = 5'h04;
  localparam logic [4:0] SC_MCU_RELEASE = 5'h16;
  localparam logic [7:0] MCU_RELEASE_VAL = 8'h01;

  // Low 16 bits of the generator multiplier 1103515245 and increment 12345.
  localparam logic [15:0] KEY_MUL = 16'h4E6D;
  localparam logic [15:0] KEY_INC = 16'h3039;

  typedef struct packed {
    region_t     region;
    logic [21:0] offset;
  } decode_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        vblank_set;
    logic [23:0] addr;
    logic [7:0]  data;
  } reg_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       vblank;
    logic [7:0] chip_sel;
    logic       mcu_write;
  } reg_rsp_t;

endpackage

// ----- hdl/bbad_ifs.sv -----
// Channel interfaces of the board bus address decoder.
interface bbad_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [23:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output req_type, output bus_address, output write_byte,
                  input ready);
  modport sink (input valid, input req_type, input bus_address, input write_byte,
                output ready);
endinterface

interface bbad_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  region;
  logic [21:0] region_offset;
  logic [7:0]  register_data;
  logic        is_write;
  logic        vblank_flag;
  logic [7:0]  chip_select_value;
  logic        mcu_status_write;

  modport source (output valid, output region, output region_offset, output register_data,
                  output is_write, output vblank_flag, output chip_select_value,
                  output mcu_status_write, input ready);
  modport sink (input valid, input region, input region_offset, input register_data,
                input is_write, input vblank_flag, input chip_select_value,
                input mcu_status_write, output ready);
endinterface

interface bbad_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hdl/board_bus_address_decoder_top.sv -----
// Top level of the board bus address decoder with its two-register pipeline.
//
//   Channel  Direction  Carries
//   in_ch    sink       req_type, bus_address, write_byte
//   out_ch   source     region, region_offset, register_data, flags, chip select
//   cfg_ch   sink       reg_index, wr_data (always ready)
//
// One transaction is accepted per cycle unless out_ch stalls.
// The decode and register update sit between the input register and the result register.
// Reset clears both valid flags, the system-control bytes, the generator and chip select.
// While the result waits, the input register still takes one more transaction.
`include "board_bus_address_decoder_top_defines.svh"

module board_bus_address_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  bbad_in_if.sink    in_ch,
  bbad_out_if.source out_ch,
  bbad_cfg_if.sink   cfg_ch
);
  import bbad_pkg::*;

  logic        s1_v_r;
  req_t        s1_type_r;
  logic [23:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        out_v_r;
  region_t     out_region_r;
  logic [21:0] out_offset_r;
  logic [7:0]  out_rdata_r;
  logic        out_wr_r;
  logic        out_vb_r;
  logic [7:0]  out_cs_r;
  logic        out_mcu_r;
  logic        advance;
  logic        fire;
  logic        in_ready;
  decode_t     dec;
  reg_req_t    req;
  reg_rsp_t    rsp;
  region_t     region_nxt;
  logic [21:0] offset_nxt;
  logic        wr_nxt;

  assign advance  = !out_v_r || out_ch.ready;
  assign fire     = s1_v_r && advance;
  assign in_ready = !s1_v_r || advance;
  assign in_ch.ready = in_ready;

  bbad_decode u_decode (
    .addr (s1_addr_r),
    .dec  (dec)
  );

  always_comb begin
    region_nxt = REGION_NONE;
    offset_nxt = '0;
    wr_nxt     = 1'b0;
    case (s1_type_r)
      REQ_READ, REQ_WRITE: begin
        region_nxt = dec.region;
        offset_nxt = dec.offset;
        wr_nxt     = s1_type_r == REQ_WRITE && dec.region != REGION_NONE;
      end
      default: begin
        region_nxt = REGION_NONE;
      end
    endcase
    req.rd         = fire && s1_type_r == REQ_READ && dec.region == REGION_NONE;
    req.wr         = fire && s1_type_r == REQ_WRITE && dec.region == REGION_NONE;
    req.vblank_set = fire && s1_type_r == REQ_VBLANK;
    req.addr       = s1_addr_r;
    req.data       = s1_data_r;
  end

  bbad_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rsp    (rsp),
    .cfg_ch (cfg_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
    end
    if (in_ready && in_ch.valid) begin
      s1_type_r <= req_t'(in_ch.req_type);
      s1_addr_r <= in_ch.bus_address;
      s1_data_r <= in_ch.write_byte;
    end
    if (fire) begin
      out_region_r <= region_nxt;
      out_offset_r <= offset_nxt;
      out_rdata_r  <= rsp.rdata;
      out_wr_r     <= wr_nxt;
      out_vb_r     <= rsp.vblank;
      out_cs_r     <= rsp.chip_sel;
      out_mcu_r    <= rsp.mcu_write;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.region            = out_region_r;
  assign out_ch.region_offset     = out_offset_r;
  assign out_ch.register_data     = out_rdata_r;
  assign out_ch.is_write          = out_wr_r;
  assign out_ch.vblank_flag       = out_vb_r;
  assign out_ch.chip_select_value = out_cs_r;
  assign out_ch.mcu_status_write  = out_mcu_r;

  `BBAD_ASSERT_NEXT(a_s1_held, s1_v_r && !advance, s1_v_r && $stable(s1_addr_r),
                    "stalled transaction lost")
  `BBAD_ASSERT_IMPL(a_none_no_offset, out_v_r && out_region_r == REGION_NONE,
                    out_offset_r == '0, "offset without region")
  `BBAD_ASSERT_IMPL(a_write_region, out_v_r && out_wr_r,
                    out_region_r != REGION_NONE && out_rdata_r == '0, "region write inconsistent")
  `BBAD_ASSERT_IMPL(a_mcu_register, out_v_r && out_mcu_r,
                    out_region_r == REGION_NONE && !out_wr_r, "MCU release on region access")
  `BBAD_ASSERT_NEXT(a_vblank_set, fire && s1_type_r == REQ_VBLANK, out_v_r && out_vb_r,
                    "vblank event not reported")
endmodule

// ----- hdl/bbad_decode.sv -----
// Priority address decoder for the fifteen external memory regions.
module bbad_decode (
  input  logic [23:0]      addr,
  output bbad_pkg::decode_t dec
);
  import bbad_pkg::*;

  logic [3:0]  hit_idx;
  logic        hit;
  logic [23:0] base;

  always_comb begin
    hit     = 1'b0;
    hit_idx = 4'd0;
    for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
      if (addr >= REGION_LO[i] && addr < REGION_HI[i]) begin
        hit     = 1'b1;
        hit_idx = 4'(i);
      end
    end
    base = REGION_LO[hit_idx];
  end

  always_comb begin
    if (hit) begin
      dec.region = region_t'(hit_idx + 4'd1);
      dec.offset = 22'(addr - base);
    end else begin
      dec.region = REGION_NONE;
      dec.offset = '0;
    end
  end
endmodule

// ----- hdl/bbad_regs.sv -----
// On-board registers: system control, key-chip generator, DIP, ports, chip select.
module bbad_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  bbad_pkg::reg_req_t req,
  output bbad_pkg::reg_rsp_t rsp,
  bbad_cfg_if.sink           cfg_ch
);
  import bbad_pkg::*;

  logic [7:0]  sc_r [32];
  logic [15:0] rw_r;
  logic [15:0] rw_nxt;
  logic [15:0] lcg_prod;
  logic        vb_r;
  logic        vb_nxt;
  logic [7:0]  cs_r;
  logic [7:0]  cs_nxt;
  logic [7:0]  dip_r;
  logic [7:0]  port_r;
  logic        sc_hit;
  logic        key_hit;
  logic        dip_hit;
  logic        port_hit;
  logic        cs_hit;
  logic [4:0]  sc_off;
  logic        sc_wr;
  logic        cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  assign sc_hit   = req.addr[23:5] == SC_BASE[23:5];
  assign key_hit  = req.addr[23:5] == KEY_BASE[23:5];
  assign dip_hit  = req.addr[23:2] == DIP_BASE[23:2];
  assign port_hit = req.addr[23:4] == PORT_BASE[23:4];
  assign cs_hit   = req.addr[23:2] == CS_BASE[23:2];
  assign sc_off   = req.addr[4:0];
  assign sc_wr    = req.wr && sc_hit;

  assign lcg_prod = rw_r * KEY_MUL;
  assign rw_nxt   = lcg_prod + KEY_INC;

  always_comb begin
    if (req.vblank_set) begin
      vb_nxt = 1'b1;
    end else if (sc_wr && sc_off == SC_VBLANK_ACK) begin
      vb_nxt = 1'b0;
    end else begin
      vb_nxt = vb_r;
    end
    cs_nxt = (req.wr && cs_hit) ? req.data : cs_r;
  end

  always_comb begin
    rsp.rdata = '0;
    if (req.rd) begin
      if (sc_hit) begin
        rsp.rdata = sc_r[sc_off];
      end else if (key_hit) begin
        rsp.rdata = rw_nxt[7:0];
      end else if (dip_hit) begin
        rsp.rdata = dip_r;
      end else if (port_hit) begin
        rsp.rdata = port_r;
      end
    end
    rsp.vblank    = vb_nxt;
    rsp.chip_sel  = cs_nxt;
    rsp.mcu_write = sc_wr && sc_off == SC_MCU_RELEASE && req.data == MCU_RELEASE_VAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        sc_r[i] <= '0;
      end
      rw_r   <= '0;
      vb_r   <= 1'b0;
      cs_r   <= '0;
      dip_r  <= 8'hFF;
      port_r <= 8'hFF;
    end else begin
      if (sc_wr) begin
        sc_r[sc_off] <= req.data;
      end
      vb_r <= vb_nxt;
      cs_r <= cs_nxt;
      if (req.rd && !sc_hit && key_hit) begin
        rw_r <= rw_nxt;
      end else if (cfg_fire && cfg_ch.reg_index == CFG_KEYCUS_SEED) begin
        rw_r <= cfg_ch.wr_data;
      end
      if (cfg_fire && cfg_ch.reg_index == CFG_DIP_SWITCH) begin
        dip_r <= cfg_ch.wr_data[7:0];
      end
      if (cfg_fire && cfg_ch.reg_index == CFG_PORT_BITS) begin
        port_r <= cfg_ch.wr_data[7:0];
      end
    end
  end
endmodule

// ----- tb/bbad_tb_pkg.sv -----
// Expected-result scoreboard and address map used by the bus decoder testbench.
`timescale 1ns / 1ps

package bbad_tb_pkg;
  import bbad_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [23:0] WIN_LO [15] = '{
    24'h000000, 24'hE00000, 24'h828000, 24'h880000, 24'h89E000,
    24'h8A0000, 24'h980000, 24'h900000, 24'h940000, 24'hC00000,
    24'hA04000, 24'hF80000, 24'h810000, 24'h824000, 24'h460000
  };
  localparam logic [23:0] WIN_HI [15] = '{
    24'h400000, 24'hE40000, 24'h840000, 24'h89E000, 24'h8A0000,
    24'h8A0010, 24'h9B0000, 24'h910000, 24'h940080, 24'hC20000,
    24'hA0C000, 24'hFA0000, 24'h810400, 24'h824400, 24'h464000
  };

  localparam logic [23:0] SYSCTL_ADDR  = 24'h700000;
  localparam logic [23:0] KEYCHIP_ADDR = 24'h400000;
  localparam logic [23:0] DIP_ADDR     = 24'h440000;
  localparam logic [23:0] PORT_ADDR    = 24'h450000;
  localparam logic [23:0] CHIPSEL_ADDR = 24'h800000;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;

  typedef struct packed {
    region_t     region;
    logic [21:0] offset;
    logic [7:0]  rdata;
    logic        wr;
    logic        vblank;
    logic [7:0]  chip_sel;
    logic        mcu;
  } access_result_t;

  class access_scoreboard;
    logic [7:0]     sysctl [32];
    logic [15:0]    key_word;
    logic [7:0]     dip_byte;
    logic [7:0]     port_byte;
    logic [7:0]     chip_sel;
    logic           vblank;
    access_result_t due [$];
    int             errors;

    function new();
      foreach (sysctl[i]) sysctl[i] = 8'h00;
      key_word = 16'h0000;
      dip_byte = 8'hFF;
      port_byte = 8'hFF;
      chip_sel = 8'h00;
      vblank = 1'b0;
      errors = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_KEYCUS_SEED: key_word = value;
        CFG_DIP_SWITCH: dip_byte = value[7:0];
        CFG_PORT_BITS: port_byte = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_access(logic [1:0] kind, logic [23:0] addr, logic [7:0] data);
      access_result_t r;
      logic [31:0]    lcg;
      int             hit;
      r = '0;
      hit = -1;
      if (kind == REQ_READ || kind == REQ_WRITE) begin
        for (int i = 0; i < 15; i++) begin
          if (hit < 0 && addr >= WIN_LO[i] && addr < WIN_HI[i]) hit = i;
        end
        if (hit >= 0) begin
          r.region = region_t'(hit + 1);
          r.offset = 22'(addr - WIN_LO[hit]);
          r.wr = (kind == REQ_WRITE);
        end else if (kind == REQ_READ) begin
          if (addr >= SYSCTL_ADDR && addr < SYSCTL_ADDR + 24'h20) begin
            r.rdata = sysctl[addr[4:0]];
          end else if (addr >= KEYCHIP_ADDR && addr < KEYCHIP_ADDR + 24'h20) begin
            lcg = {16'h0000, key_word} * LCG_MUL + LCG_INC;
            key_word = lcg[15:0];
            r.rdata = key_word[7:0];
          end else if (addr >= DIP_ADDR && addr < DIP_ADDR + 24'h4) begin
            r.rdata = dip_byte;
          end else if (addr >= PORT_ADDR && addr < PORT_ADDR + 24'h10) begin
            r.rdata = port_byte;
          end
        end else begin
          if (addr >= SYSCTL_ADDR && addr < SYSCTL_ADDR + 24'h20) begin
            sysctl[addr[4:0]] = data;
            if (addr[4:0] == SC_VBLANK_ACK) vblank = 1'b0;
            r.mcu = (addr[4:0] == SC_MCU_RELEASE && data == MCU_RELEASE_VAL);
          end else if (addr >= CHIPSEL_ADDR && addr < CHIPSEL_ADDR + 24'h4) begin
            chip_sel = data;
          end
        end
      end else if (kind == REQ_VBLANK) begin
        vblank = 1'b1;
      end
      r.vblank = vblank;
      r.chip_sel = chip_sel;
      due.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(access_result_t got);
      access_result_t want;
      if (due.size() == 0) begin
        report($sformatf("result with no transaction outstanding, region %0d", got.region));
        return;
      end
      want = due.pop_front();
      if (got.region !== want.region)
        report($sformatf("region %0d, expected %0d", got.region, want.region));
      if (got.offset !== want.offset)
        report($sformatf("region_offset %h, expected %h", got.offset, want.offset));
      if (got.rdata !== want.rdata)
        report($sformatf("register_data %h, expected %h", got.rdata, want.rdata));
      if (got.wr !== want.wr)
        report($sformatf("is_write %b, expected %b", got.wr, want.wr));
      if (got.vblank !== want.vblank)
        report($sformatf("vblank_flag %b, expected %b", got.vblank, want.vblank));
      if (got.chip_sel !== want.chip_sel)
        report($sformatf("chip_select_value %h, expected %h", got.chip_sel, want.chip_sel));
      if (got.mcu !== want.mcu)
        report($sformatf("mcu_status_write %b, expected %b", got.mcu, want.mcu));
    endtask
  endclass

endpackage

// ----- tb/tb.sv -----
// Top-level testbench driving directed and random bus accesses through the decoder.
`timescale 1ns / 1ps

module tb;
  import bbad_pkg::*;
  import bbad_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SEND_IDLE [PHASES] = '{0, 78, 0, 14, 0};
  localparam int RECV_STALL [PHASES] = '{0, 0, 78, 14, 0};

  logic clk = 1'b0;
  logic rst_n;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   cycle_count;

  access_scoreboard sb;

  bbad_in_if  in_ch ();
  bbad_out_if out_ch ();
  bbad_cfg_if cfg_ch ();

  board_bus_address_decoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(access_result_t'{region_t'(out_ch.region), out_ch.region_offset,
                                       out_ch.register_data, out_ch.is_write,
                                       out_ch.vblank_flag, out_ch.chip_select_value,
                                       out_ch.mcu_status_write});
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_access(logic [1:0] kind, logic [23:0] addr, logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.bus_address <= addr;
    in_ch.write_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_access(kind, addr, data);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.configure(idx, value);
  endtask

  function automatic logic [23:0] random_address();
    int          i;
    logic [23:0] span;
    i = $urandom_range(14);
    span = WIN_HI[i] - WIN_LO[i];
    case ($urandom_range(9))
      0, 1: return 24'($urandom);
      2: return WIN_LO[i] + 24'($urandom_range(3));
      3: return WIN_HI[i] + 24'($urandom_range(2)) - 24'd1;
      4: return WIN_LO[i] + 24'($urandom_range(int'(span) - 1));
      5, 6: begin
        if ($urandom_range(2) == 0) return SYSCTL_ADDR + 24'($urandom_range(33));
        if ($urandom_range(1) == 0) return SYSCTL_ADDR + {19'h0, SC_VBLANK_ACK};
        return SYSCTL_ADDR + {19'h0, SC_MCU_RELEASE};
      end
      7: return KEYCHIP_ADDR + 24'($urandom_range(35));
      8: begin
        if ($urandom_range(1) == 0) return DIP_ADDR + 24'($urandom_range(5));
        return PORT_ADDR + 24'($urandom_range(17));
      end
      default: return CHIPSEL_ADDR + 24'($urandom_range(5));
    endcase
  endfunction

  task automatic send_random_access();
    logic [1:0]  kind;
    logic [7:0]  data;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45) kind = REQ_READ;
    else if (pick < 85) kind = REQ_WRITE;
    else if (pick < 95) kind = REQ_VBLANK;
    else kind = REQ_UNUSED;
    data = ($urandom_range(3) == 0) ? MCU_RELEASE_VAL : 8'($urandom);
    send_access(kind, random_address(), data);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_READ;
    in_ch.bus_address = 24'h0;
    in_ch.write_byte = 8'h0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_KEYCUS_SEED;
    cfg_ch.wr_data = 16'h0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = SEND_IDLE[p];
      receiver_stall_pct = RECV_STALL[p];
      wait_drained();
      repeat (4) @(posedge clk);
      case (p)
        0: begin
          write_register(CFG_KEYCUS_SEED, 16'h0000);
          write_register(CFG_DIP_SWITCH, 16'h0000);
          write_register(CFG_PORT_BITS, 16'h00FF);
        end
        1: begin
          write_register(CFG_KEYCUS_SEED, 16'hFFFF);
          write_register(CFG_DIP_SWITCH, 16'hFFFF);
          write_register(CFG_PORT_BITS, 16'hFF00);
        end
        4: begin
          write_register(CFG_KEYCUS_SEED, 16'h0001);
          write_register(CFG_DIP_SWITCH, 16'h335A);
          write_register(CFG_PORT_BITS, 16'hCCA5);
        end
        default: begin
          write_register(CFG_KEYCUS_SEED, 16'($urandom));
          write_register(CFG_DIP_SWITCH, 16'($urandom));
          write_register(CFG_PORT_BITS, 16'($urandom));
        end
      endcase
      cfg_ch.valid <= 1'b0;

      if (p == 0) begin
        send_access(REQ_READ, 24'h000000, 8'h00);
        send_access(REQ_READ, 24'h3FFFFF, 8'hFF);
        send_access(REQ_WRITE, 24'hE00000, 8'hFF);
        send_access(REQ_READ, 24'hE3FFFF, 8'h00);
        send_access(REQ_WRITE, 24'h89DFFF, 8'h5A);
        send_access(REQ_READ, 24'h89E000, 8'h00);
        send_access(REQ_READ, 24'h8A000F, 8'h00);
        send_access(REQ_READ, 24'h8A0010, 8'h00);
        send_access(REQ_WRITE, 24'h940080, 8'h77);
        send_access(REQ_WRITE, 24'h463FFF, 8'hA5);
        send_access(REQ_READ, 24'hFFFFFF, 8'hFF);
        send_access(REQ_VBLANK, 24'hFFFFFF, 8'hFF);
        send_access(REQ_WRITE, SYSCTL_ADDR + {19'h0, SC_VBLANK_ACK}, 8'h00);
        send_access(REQ_VBLANK, 24'h000000, 8'h00);
        send_access(REQ_WRITE, SYSCTL_ADDR + {19'h0, SC_MCU_RELEASE}, MCU_RELEASE_VAL);
        send_access(REQ_WRITE, SYSCTL_ADDR + {19'h0, SC_MCU_RELEASE}, 8'h02);
        send_access(REQ_READ, SYSCTL_ADDR + {19'h0, SC_MCU_RELEASE}, 8'h00);
        send_access(REQ_READ, SYSCTL_ADDR + 24'h1F, 8'h00);
        send_access(REQ_READ, KEYCHIP_ADDR, 8'h00);
        send_access(REQ_READ, KEYCHIP_ADDR + 24'h1F, 8'h00);
        send_access(REQ_READ, DIP_ADDR, 8'h00);
        send_access(REQ_READ, PORT_ADDR + 24'hF, 8'h00);
        send_access(REQ_WRITE, CHIPSEL_ADDR + 24'h3, 8'hA5);
        send_access(REQ_WRITE, KEYCHIP_ADDR, 8'h3C);
        send_access(REQ_UNUSED, SYSCTL_ADDR + {19'h0, SC_VBLANK_ACK}, 8'h00);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 3 || $urandom_range(199) == 0) wait_drained();
        send_random_access();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
